// ===== rtl/uclm_pkg.sv =====
// ----------------------------------------------------------------------------
// uclm_pkg
// Shared types and constants for the user context list manager.
// ----------------------------------------------------------------------------
package uclm_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LNK_W   = IDX_W + 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [LNK_W-1:0] NIL = LNK_W'(ENTRIES);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_SWAP   = 3'd3;
    localparam logic [2:0] OP_REQ    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] user_ident;
        logic [2:0]  carrier;
        logic [3:0]  entry_a;
        logic [3:0]  entry_b;
        logic        list_select;
    } cmd_t;

    typedef struct packed {
        logic [3:0] entry_index;
        logic [1:0] status;
        logic [4:0] active_count;
    } rsp_t;

endpackage

// ===== rtl/uclm_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// uclm_cmd_queue
// Two-entry command queue between the front end and the list engine.
// ----------------------------------------------------------------------------
module uclm_cmd_queue
    import uclm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output logic empty,
    output logic full,
    output cmd_t head
);
    cmd_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = mem_reg[rd_reg];

    // store a transfer
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop && !empty)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");
    a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_reg == rd_reg))
        else $error("queue pointers out of step");
endmodule

// ===== rtl/uclm_engine.sv =====
// ----------------------------------------------------------------------------
// uclm_engine
// List engine: executes one command at a time, walking links one per cycle.
// ----------------------------------------------------------------------------
module uclm_engine
    import uclm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic idle,
    output logic result_valid,
    output rsp_t result
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_RMUP  = 4'd3;
    localparam logic [3:0] S_RMFIN = 4'd4;
    localparam logic [3:0] S_SWPJ  = 4'd5;
    localparam logic [3:0] S_SWFIN = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    localparam logic [1:0] W_FIND = 2'd0;
    localparam logic [1:0] W_PREV = 2'd1;

    logic [LNK_W-1:0] dn_reg  [ENTRIES];
    logic [LNK_W-1:0] up_reg  [ENTRIES];
    logic [15:0]      id_reg  [ENTRIES];
    logic [2:0]       car_reg [ENTRIES];
    logic [ENTRIES-1:0] use_reg, rq_reg;
    logic [LNK_W-1:0] dh_reg, uh_reg, fh_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [3:0]       st_reg;
    cmd_t             c_reg;
    logic [1:0]       wk_reg;
    logic             wl_reg;       // list being walked: 0 down, 1 up
    logic [LNK_W-1:0] tgt_reg, cur_reg, pi_reg, pj_reg;
    logic [CNT_W-1:0] steps_reg;
    rsp_t             res_reg;
    logic             rv_reg;

    logic [IDX_W-1:0] a, b, ci;
    logic [LNK_W-1:0] la, lb, nx, hd, ni, nj;
    logic             cur_ok;

    assign a      = c_reg.entry_a[IDX_W-1:0];
    assign b      = c_reg.entry_b[IDX_W-1:0];
    assign la     = LNK_W'(c_reg.entry_a);
    assign lb     = LNK_W'(c_reg.entry_b);
    assign ci     = cur_reg[IDX_W-1:0];
    assign cur_ok = (cur_reg < NIL) && (steps_reg < CNT_W'(ENTRIES));
    assign nx     = wl_reg ? up_reg[ci] : dn_reg[ci];
    assign hd     = c_reg.list_select ? uh_reg : dh_reg;
    assign ni     = c_reg.list_select ? up_reg[a] : dn_reg[a];
    assign nj     = c_reg.list_select ? up_reg[b] : dn_reg[b];

    assign cmd_pop      = (st_reg == S_IDLE) && cmd_valid;
    assign idle         = (st_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // sequence commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            rv_reg    <= 1'b0;
            dh_reg    <= NIL;
            uh_reg    <= NIL;
            fh_reg    <= '0;
            cnt_reg   <= '0;
            use_reg   <= '0;
            rq_reg    <= '0;
            c_reg     <= '0;
            res_reg   <= '0;
            wk_reg    <= W_FIND;
            wl_reg    <= 1'b0;
            tgt_reg   <= NIL;
            cur_reg   <= NIL;
            pi_reg    <= NIL;
            pj_reg    <= NIL;
            steps_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                dn_reg[i]  <= LNK_W'(i + 1);
                up_reg[i]  <= NIL;
                id_reg[i]  <= '0;
                car_reg[i] <= '0;
            end
        end
        else
        begin
            rv_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg   <= cmd;
                        res_reg <= '{entry_index: 4'd0, status: ST_OK, active_count: cnt_reg};
                        st_reg  <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    st_reg  <= S_DONE;
                    case (c_reg.opcode)
                        OP_ADD:
                        begin
                            if (fh_reg >= NIL)
                            begin
                                res_reg.status <= ST_FULL;
                            end
                            else
                            begin
                                fh_reg <= dn_reg[fh_reg[IDX_W-1:0]];
                                dn_reg[fh_reg[IDX_W-1:0]]  <= dh_reg;
                                up_reg[fh_reg[IDX_W-1:0]]  <= uh_reg;
                                id_reg[fh_reg[IDX_W-1:0]]  <= c_reg.user_ident;
                                car_reg[fh_reg[IDX_W-1:0]] <= c_reg.carrier;
                                use_reg[fh_reg[IDX_W-1:0]] <= 1'b1;
                                dh_reg  <= fh_reg;
                                uh_reg  <= fh_reg;
                                cnt_reg <= cnt_reg + 1'b1;
                                res_reg.entry_index  <= 4'(fh_reg[IDX_W-1:0]);
                                res_reg.active_count <= cnt_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (la >= NIL || !use_reg[a])
                            begin
                                res_reg.status <= ST_NOTFOUND;
                            end
                            else if (dh_reg == la)
                            begin
                                dh_reg <= dn_reg[a];
                                st_reg <= S_RMUP;
                            end
                            else
                            begin
                                wk_reg <= W_PREV; wl_reg <= 1'b0; tgt_reg <= la;
                                cur_reg <= dh_reg; steps_reg <= '0; st_reg <= S_WALK;
                            end
                        end
                        OP_FIND, OP_REQ:
                        begin
                            wk_reg <= W_FIND; wl_reg <= 1'b0;
                            cur_reg <= dh_reg; steps_reg <= '0; st_reg <= S_WALK;
                        end
                        OP_SWAP:
                        begin
                            if (la >= NIL || lb >= NIL || !use_reg[a] || !use_reg[b])
                            begin
                                res_reg.status <= ST_NOTFOUND;
                            end
                            else if (a == b)
                            begin
                                res_reg.entry_index <= c_reg.entry_a;
                            end
                            else if (hd == la)
                            begin
                                pi_reg <= NIL;
                                st_reg <= S_SWPJ;
                            end
                            else
                            begin
                                wk_reg <= W_PREV; wl_reg <= c_reg.list_select; tgt_reg <= la;
                                cur_reg <= hd; steps_reg <= '0; st_reg <= S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
                S_WALK:
                begin
                    if (wk_reg == W_FIND)
                    begin
                        if (!cur_ok)
                        begin
                            res_reg.status <= ST_NOTFOUND;
                            st_reg <= S_DONE;
                        end
                        else if (id_reg[ci] == c_reg.user_ident)
                        begin
                            if (c_reg.opcode == OP_REQ)
                            begin
                                rq_reg[ci] <= 1'b1;
                            end
                            res_reg.entry_index <= 4'(ci);
                            st_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg <= nx; steps_reg <= steps_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (!cur_ok || nx == tgt_reg)
                        begin
                            // predecessor found (or none)
                            if (c_reg.opcode == OP_REMOVE)
                            begin
                                if (cur_ok)
                                begin
                                    if (wl_reg) up_reg[ci] <= up_reg[a];
                                    else        dn_reg[ci] <= dn_reg[a];
                                end
                                st_reg <= wl_reg ? S_RMFIN : S_RMUP;
                            end
                            else if (tgt_reg == la)
                            begin
                                pi_reg <= cur_ok ? cur_reg : NIL;
                                st_reg <= S_SWPJ;
                            end
                            else
                            begin
                                pj_reg <= cur_ok ? cur_reg : NIL;
                                st_reg <= S_SWFIN;
                            end
                        end
                        else
                        begin
                            cur_reg <= nx; steps_reg <= steps_reg + 1'b1;
                        end
                    end
                end
                S_RMUP:
                begin
                    if (uh_reg == la)
                    begin
                        uh_reg <= up_reg[a];
                        st_reg <= S_RMFIN;
                    end
                    else
                    begin
                        wk_reg <= W_PREV; wl_reg <= 1'b1; tgt_reg <= la;
                        cur_reg <= uh_reg; steps_reg <= '0; st_reg <= S_WALK;
                    end
                end
                S_RMFIN:
                begin
                    dn_reg[a]  <= fh_reg;
                    fh_reg     <= la;
                    up_reg[a]  <= NIL;
                    use_reg[a] <= 1'b0;
                    id_reg[a]  <= '0;
                    rq_reg[a]  <= 1'b0;
                    cnt_reg    <= (cnt_reg != 0) ? cnt_reg - 1'b1 : cnt_reg;
                    res_reg.entry_index  <= c_reg.entry_a;
                    res_reg.active_count <= (cnt_reg != 0) ? cnt_reg - 1'b1 : cnt_reg;
                    st_reg <= S_DONE;
                end
                S_SWPJ:
                begin
                    if (hd == lb)
                    begin
                        pj_reg <= NIL;
                        st_reg <= S_SWFIN;
                    end
                    else
                    begin
                        wk_reg <= W_PREV; wl_reg <= c_reg.list_select; tgt_reg <= lb;
                        cur_reg <= hd; steps_reg <= '0; st_reg <= S_WALK;
                    end
                end
                S_SWFIN:
                begin
                    // relink per adjacency case
                    if (ni == lb)
                    begin
                        if (c_reg.list_select)
                        begin
                            up_reg[a] <= nj; up_reg[b] <= la;
                            if (pi_reg < NIL) up_reg[pi_reg[IDX_W-1:0]] <= lb; else uh_reg <= lb;
                        end
                        else
                        begin
                            dn_reg[a] <= nj; dn_reg[b] <= la;
                            if (pi_reg < NIL) dn_reg[pi_reg[IDX_W-1:0]] <= lb; else dh_reg <= lb;
                        end
                    end
                    else if (nj == la)
                    begin
                        if (c_reg.list_select)
                        begin
                            up_reg[b] <= ni; up_reg[a] <= lb;
                            if (pj_reg < NIL) up_reg[pj_reg[IDX_W-1:0]] <= la; else uh_reg <= la;
                        end
                        else
                        begin
                            dn_reg[b] <= ni; dn_reg[a] <= lb;
                            if (pj_reg < NIL) dn_reg[pj_reg[IDX_W-1:0]] <= la; else dh_reg <= la;
                        end
                    end
                    else
                    begin
                        if (c_reg.list_select)
                        begin
                            up_reg[b] <= ni; up_reg[a] <= nj;
                            if (pi_reg < NIL) up_reg[pi_reg[IDX_W-1:0]] <= lb;
                            if (pj_reg < NIL) up_reg[pj_reg[IDX_W-1:0]] <= la;
                            if (pj_reg >= NIL) uh_reg <= la;
                            else if (pi_reg >= NIL) uh_reg <= lb;
                        end
                        else
                        begin
                            dn_reg[b] <= ni; dn_reg[a] <= nj;
                            if (pi_reg < NIL) dn_reg[pi_reg[IDX_W-1:0]] <= lb;
                            if (pj_reg < NIL) dn_reg[pj_reg[IDX_W-1:0]] <= la;
                            if (pj_reg >= NIL) dh_reg <= la;
                            else if (pi_reg >= NIL) dh_reg <= lb;
                        end
                    end
                    res_reg.entry_index <= c_reg.entry_a;
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rv_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("count above table size");
    a_rv_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(rv_reg && st_reg != S_IDLE))
        else $error("result outside idle");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg == S_WALK && steps_reg > CNT_W'(ENTRIES)))
        else $error("walk overrun");
endmodule

// ===== rtl/user_context_list_manager.sv =====
// ----------------------------------------------------------------------------
// user_context_list_manager
// User context table with downlink, uplink and free lists.
// ----------------------------------------------------------------------------
// For find, request, remove and swap the list engine walks one link per
// cycle, so the position of the entries in the lists sets the time; add and
// the unused opcodes walk no list. A command that waits in the queue behind
// another adds that command's time. The front end keeps busy low while the
// two-entry command queue has room, and each command gives one result, on
// result for one cycle with done high. The receiver cannot stall done.
module user_context_list_manager
    import uclm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t result
);
    logic q_empty, q_full, pop, eng_idle;
    cmd_t q_head;

    assign busy = q_full;

    uclm_cmd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(start), .push_data(cmd),
        .pop(pop), .empty(q_empty), .full(q_full), .head(q_head)
    );

    uclm_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(!q_empty), .cmd(q_head), .cmd_pop(pop),
        .idle(eng_idle), .result_valid(done), .result(result)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> eng_idle)
        else $error("done while engine active");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !q_empty)
        else $error("accepted transfer lost");
endmodule
